// ----- design/backend_health_stats_table_assert.svh -----
// Assertion macros for the backend health statistics table.
`ifndef BACKEND_HEALTH_STATS_TABLE_ASSERT_SVH
`define BACKEND_HEALTH_STATS_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define BHST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BHST_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHST_ASSERT(label, clk, rst_n, prop, msg)
`define BHST_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- design/bhst_pkg.sv -----
// Shared types and constants for the backend health statistics table.
`timescale 1ns / 1ps
package bhst_pkg;
  typedef struct packed {
    logic        mode;
    logic [2:0]  server_index;
    logic        success;
    logic [23:0] resp_us;
  } bhst_in_t;

  typedef struct packed {
    logic        server_healthy;
    logic [15:0] server_in_flight;
    logic [23:0] server_avg_time;
    logic [14:0] server_fail_rate;
    logic [23:0] pool_avg_time;
  } bhst_out_t;

  localparam logic [1:0] DIV_SRV_AVG  = 2'd0;
  localparam logic [1:0] DIV_SRV_RATE = 2'd1;
  localparam logic [1:0] DIV_POOL_AVG = 2'd2;

  localparam logic [1:0] ADDR_FAIL_THR = 2'd0;

  typedef struct packed {
    logic       load;
    logic       update;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_store;
    logic       emit;
  } bhst_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_end;
    logic idx_ok;
  } bhst_sts_t;

  localparam logic [7:0]  FailThresholdReset = 8'd3;
  localparam logic [23:0] Max24 = 24'hFFFFFF;
  localparam logic [14:0] RateMax = 15'd25600;
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
endpackage

// ----- design/bhst_ctrl.sv -----
// Sequencer for the statistics table: update, three divisions for a request end with a valid index, result.
`timescale 1ns / 1ps
module bhst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  bhst_pkg::bhst_sts_t sts_i,
  output bhst_pkg::bhst_cmd_t cmd_o
);
  import bhst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_SRV_AVG;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.div_sel = sel_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        sel_d = DIV_SRV_AVG;
        state_d = (sts_i.is_end && sts_i.idx_ok) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sel_q == DIV_POOL_AVG) begin
            state_d = S_OUT;
          end else begin
            sel_d = sel_q + 2'd1;
            state_d = S_DIV;
          end
        end
      end
      S_OUT: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

// ----- design/bhst_div.sv -----
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module bhst_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    shifted = {rem_q, quot_q[63]};
    trial   = shifted - {1'b0, dvs_q};
    done_o  = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 7'd64;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (cnt_q == 7'd0) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 7'd1;
        if (!trial[32]) begin
          rem_d  = trial[31:0];
          quot_d = {quot_q[62:0], 1'b1};
        end else begin
          rem_d  = shifted[31:0];
          quot_d = {quot_q[62:0], 1'b0};
        end
      end
    end
  end

  assign quot_o = (dvs_q == '0) ? 64'd0 : quot_q;
endmodule

// ----- design/bhst_dp.sv -----
// Datapath: per-server statistics table, pool totals and result register.
`timescale 1ns / 1ps
module bhst_dp #(
  parameter int NUM_SERVERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bhst_pkg::bhst_in_t  req_i,
  input  logic [7:0]          thresh_i,
  input  bhst_pkg::bhst_cmd_t cmd_i,
  output bhst_pkg::bhst_sts_t sts_o,
  output logic                valid_o,
  output bhst_pkg::bhst_out_t res_o
);
  import bhst_pkg::*;

  localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  logic        healthy_q [NUM_SERVERS];
  logic [7:0]  cfail_q   [NUM_SERVERS];
  logic [15:0] infl_q    [NUM_SERVERS];
  logic [31:0] sreq_q    [NUM_SERVERS];
  logic [31:0] sfail_q   [NUM_SERVERS];
  logic [47:0] ssum_q    [NUM_SERVERS];
  logic [23:0] savg_q    [NUM_SERVERS];
  logic [14:0] srate_q   [NUM_SERVERS];
  logic [31:0] preq_q, pfail_q;
  logic [47:0] psum_q;
  logic [23:0] pavg_q;

  bhst_in_t    req_q;
  logic        valid_q;
  bhst_out_t   res_q;
  logic [IW-1:0] ix;
  logic        idx_ok;
  logic        fail;
  logic [63:0] dividend;
  logic [31:0] divisor;
  logic        div_done;
  logic [63:0] quot;
  logic [48:0] ssum_add, psum_add;
  logic [7:0]  cf_next;

  assign idx_ok = ({29'd0, req_q.server_index} < 32'(NUM_SERVERS));
  assign ix     = IW'(req_q.server_index);
  assign fail   = !req_q.success;
  assign ssum_add = {1'b0, ssum_q[ix]} + {25'd0, req_q.resp_us};
  assign psum_add = {1'b0, psum_q} + {25'd0, req_q.resp_us};
  assign cf_next  = (cfail_q[ix] == 8'hFF) ? 8'hFF : cfail_q[ix] + 8'd1;

  assign sts_o.div_done = div_done;
  assign sts_o.is_end   = req_q.mode;
  assign sts_o.idx_ok   = idx_ok;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_SRV_AVG: begin
        dividend = {16'd0, ssum_q[ix]};
        divisor  = sreq_q[ix];
      end
      DIV_SRV_RATE: begin
        dividend = {32'd0, sfail_q[ix]} * 64'd25600;
        divisor  = sreq_q[ix];
      end
      default: begin
        dividend = {16'd0, psum_q};
        divisor  = preq_q;
      end
    endcase
  end

  bhst_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        healthy_q[i] <= 1'b1;
        cfail_q[i]   <= '0;
        infl_q[i]    <= '0;
        sreq_q[i]    <= '0;
        sfail_q[i]   <= '0;
        ssum_q[i]    <= '0;
        savg_q[i]    <= '0;
        srate_q[i]   <= '0;
      end
      preq_q  <= '0;
      pfail_q <= '0;
      psum_q  <= '0;
      pavg_q  <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      if (cmd_i.update && idx_ok) begin
        if (!req_q.mode) begin
          if (infl_q[ix] != 16'hFFFF) infl_q[ix] <= infl_q[ix] + 16'd1;
          if (sreq_q[ix] != 32'hFFFF_FFFF) sreq_q[ix] <= sreq_q[ix] + 32'd1;
          if (preq_q != 32'hFFFF_FFFF) preq_q <= preq_q + 32'd1;
        end else begin
          if (infl_q[ix] != 16'd0) infl_q[ix] <= infl_q[ix] - 16'd1;
          if (fail) begin
            if (sfail_q[ix] != 32'hFFFF_FFFF) sfail_q[ix] <= sfail_q[ix] + 32'd1;
            if (pfail_q != 32'hFFFF_FFFF) pfail_q <= pfail_q + 32'd1;
            cfail_q[ix] <= cf_next;
            if (cf_next >= thresh_i) healthy_q[ix] <= 1'b0;
          end else begin
            cfail_q[ix]   <= '0;
            healthy_q[ix] <= 1'b1;
          end
          ssum_q[ix] <= ssum_add[48] ? Max48 : ssum_add[47:0];
          psum_q     <= psum_add[48] ? Max48 : psum_add[47:0];
        end
      end
      if (cmd_i.div_store) begin
        case (cmd_i.div_sel)
          DIV_SRV_AVG:
            savg_q[ix] <= (quot > {40'd0, Max24}) ? Max24 : quot[23:0];
          DIV_SRV_RATE:
            srate_q[ix] <= (quot > {49'd0, RateMax}) ? RateMax : quot[14:0];
          default:
            pavg_q <= (quot > {40'd0, Max24}) ? Max24 : quot[23:0];
        endcase
      end
      if (cmd_i.emit) begin
        valid_q <= 1'b1;
        if (idx_ok) begin
          res_q.server_healthy   <= healthy_q[ix];
          res_q.server_in_flight <= infl_q[ix];
          res_q.server_avg_time  <= savg_q[ix];
          res_q.server_fail_rate <= srate_q[ix];
          res_q.pool_avg_time    <= pavg_q;
        end else begin
          res_q <= '0;
        end
      end
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

// ----- design/backend_health_stats_table.sv -----
// Top level of the backend health statistics table.
// Usage:
//   Command channel: drive req_i and raise start_i; the transaction is taken
//   at a rising edge with start_i high and busy_o low. busy_o stays high
//   until the cycle in which the result is shown.
//   Result channel: done_o is high for exactly one cycle with res_o valid;
//   the receiver cannot stall and must take it then.
//   Processing: a request start updates the counters; a request end with a
//   valid server index also runs three divisions one after another on a
//   single shared 64-step restoring divider (server average, server failure
//   rate, pool average).
//   Turnaround: busy_o falls as done_o rises, so the next transaction can be
//   taken while the result is shown.
//   Configuration: APB register 0 (byte address 0) is failure_threshold,
//   8 bits, reset 3; write it only while busy_o is low.
//   Reset: asynchronous, active low; all servers healthy, all counters and
//   stored averages zero, no clearing pass.
`timescale 1ns / 1ps
module backend_health_stats_table #(
  parameter int NUM_SERVERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  bhst_pkg::bhst_in_t  req_i,
  output logic                done_o,
  output bhst_pkg::bhst_out_t res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bhst_pkg::*;
`include "backend_health_stats_table_assert.svh"

  logic [7:0] thresh_q;
  bhst_cmd_t  cmd;
  bhst_sts_t  sts;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FAIL_THR) ? {24'd0, thresh_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= FailThresholdReset;
    end else if (psel && penable && pwrite && paddr == ADDR_FAIL_THR) begin
      thresh_q <= pwdata[7:0];
    end
  end

  bhst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bhst_dp #(.NUM_SERVERS(NUM_SERVERS)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .thresh_i(thresh_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .valid_o (done_o),
    .res_o   (res_o)
  );

  `BHST_ASSERT(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "accept did not raise busy")
  `BHST_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o, "result shown while busy")
  `BHST_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result held two cycles")
endmodule
